// ===== design/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the triangle depth rasterizer
// Store geometry, datapath widths, action and register codes, sequencer
// states, the bundles passed between the rasterizer's units and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

    // Store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIXELS     = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_AW     = $clog2(PIXELS);

    // Field widths
    localparam int CRD_W   = 16;
    localparam int DEPTH_W = 24;
    localparam int COLOR_W = 24;
    localparam int DIM_W   = 9;

    // Datapath widths
    localparam int BOX_W   = 14;   // whole-pixel coordinates after floor / ceil
    localparam int DIFF_W  = CRD_W + 1;
    localparam int STEP_W  = DIFF_W + 5;
    localparam int EDGE_W  = 37;
    localparam int AREA_W  = 36;
    localparam int LO_W    = 18;
    localparam int MAC_A_W = DEPTH_W + 1;
    localparam int MAC_B_W = EDGE_W - LO_W;
    localparam int PROD_W  = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = 64;
    localparam int Q_W     = DEPTH_W;

    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic [COLOR_W-1:0]        BG_RESET  = 24'hF2F5F6;
    localparam logic [DIM_W-1:0]          DIM_RESET = DIM_W'(256);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_DRAW  = 2'd1,
        ACT_READ  = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BG     = 2'd2
    } cfg_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ADDR,
        S_RD_OUT,
        S_BOX,
        S_AREA,
        S_AREA_CHK,
        S_EDGE0,
        S_EDGE1,
        S_EDGE_END,
        S_PIX,
        S_DEPTH,
        S_DIV_GO,
        S_DIV_WAIT,
        S_WRITE
    } state_t;

    // One operation for the shared multiply-accumulate unit
    typedef struct packed {
        logic                       valid;
        logic                       clear;
        logic                       sub;
        logic                       hi;
        logic signed [MAC_A_W-1:0]  a;
        logic signed [MAC_B_W-1:0]  b;
    } mac_op_t;

    // Access to the pixel store
    typedef struct packed {
        logic                       we;
        logic [PIX_AW-1:0]          addr;
        logic [COLOR_W-1:0]         color;
        logic signed [DEPTH_W-1:0]  depth;
    } pix_req_t;

    function automatic logic signed [CRD_W-1:0] min3(
        input logic signed [CRD_W-1:0] a,
        input logic signed [CRD_W-1:0] b,
        input logic signed [CRD_W-1:0] c
    );
        logic signed [CRD_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CRD_W-1:0] max3(
        input logic signed [CRD_W-1:0] a,
        input logic signed [CRD_W-1:0] b,
        input logic signed [CRD_W-1:0] c
    );
        logic signed [CRD_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [PIX_AW-1:0] pix_index(
        input logic [BOX_W-1:0] x,
        input logic [BOX_W-1:0] y
    );
        return PIX_AW'(y * MAX_WIDTH + x);
    endfunction

endpackage

`default_nettype wire

// ===== design/trd_mac.sv =====
// ----------------------------------------------------------------------------
// trd_mac: shared multiply-accumulate unit
// Two stages: a registered signed product, then an accumulate with optional
// clear, subtract and an upper-half shift for split operands.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_mac
    import trd_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mac_op_t                   op,
    output logic signed [ACC_W-1:0]        acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     valid_reg;
    logic                     clear_reg;
    logic                     sub_reg;
    logic                     hi_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term;

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= op.valid;
        end
        prod_reg  <= $signed(op.a) * $signed(op.b);
        clear_reg <= op.clear;
        sub_reg   <= op.sub;
        hi_reg    <= op.hi;
    end

    // Accumulate stage
    always_comb begin
        term = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (hi_reg) begin
            term = term <<< LO_W;
        end
        acc_next = (clear_reg ? '0 : acc_reg) + (sub_reg ? -term : term);
    end

    always_ff @(posedge aclk) begin
        if (valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== design/trd_divider.sv =====
// ----------------------------------------------------------------------------
// trd_divider: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncated toward zero.
// The quotient magnitude is known to fit Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_divider
    import trd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic signed [ACC_W-1:0]    num,
    input  wire logic [AREA_W-1:0]          den,
    output logic                            done,
    output logic signed [Q_W-1:0]           quot
);

    localparam int CNT_W = $clog2(Q_W);

    logic [ACC_W-1:0] rem_reg;
    logic [ACC_W-1:0] dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Control: count the quotient bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: compare, subtract and shift
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[ACC_W-1];
            rem_reg <= num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
            dsh_reg <= ACC_W'(den) << (Q_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (rem_reg >= dsh_reg) begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

`default_nettype wire

// ===== design/trd_pixel_store.sv =====
// ----------------------------------------------------------------------------
// trd_pixel_store: color and depth store
// One port: written at one address and read at the same address, with the
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_pixel_store
    import trd_pkg::*;
(
    input  wire logic                       aclk,
    input  wire pix_req_t                   req,
    output logic [COLOR_W-1:0]              rd_color,
    output logic signed [DEPTH_W-1:0]       rd_depth
);

    logic [COLOR_W+DEPTH_W-1:0] mem [PIXELS];
    logic [COLOR_W+DEPTH_W-1:0] rd_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= {req.color, req.depth};
        end
        rd_reg <= mem[req.addr];
    end

    assign rd_color = rd_reg[COLOR_W+DEPTH_W-1:DEPTH_W];
    assign rd_depth = rd_reg[DEPTH_W-1:0];

endmodule

`default_nettype wire

// ===== design/triangle_raster_depth_test.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_depth_test: depth-buffered triangle rasterizer
// Clears, draws into and reads back a color and depth store. A sequencer
// drives one shared multiply-accumulate unit and one iterative divider.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                       handshake
//  s_        in         tuser: action; tdata: vertices, depths, color  tvalid/tready
//  m_        out        tdata: pixel_color, pixel_depth                tvalid/tready
//  cfg_      in         cfg_index, cfg_data                            cfg_valid/cfg_ready
//
//  Clear writes one store entry a cycle, all PIXELS (65536) of them; the same
//  pass runs after reset with the background reset color, and s_tready
//  stays low. Draw sets up the box, area and edges, then steps through the
//  box pixels, one a cycle while uncovered; a covered pixel takes the depth
//  multiply-accumulate steps, the divider start, quotient bits and done
//  flag, and a write. Read holds until the output register is free.
//  One transaction is worked at a time; configuration is always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_raster_depth_test
    import trd_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    // ax, ay, a_depth, bx, by_coord, b_depth, cx, cy, c_depth, fill_color
    input  wire logic [191:0]   s_tdata,
    // action
    input  wire logic [1:0]     s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // pixel_color, pixel_depth
    output logic [47:0]         m_tdata,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [23:0]    cfg_data
);

    // Input fields
    logic signed [CRD_W-1:0]   in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    logic signed [DEPTH_W-1:0] in_da, in_db, in_dc;
    logic [COLOR_W-1:0]        in_col;

    assign in_ax  = s_tdata[15:0];
    assign in_ay  = s_tdata[31:16];
    assign in_da  = s_tdata[55:32];
    assign in_bx  = s_tdata[71:56];
    assign in_by  = s_tdata[87:72];
    assign in_db  = s_tdata[111:88];
    assign in_cx  = s_tdata[127:112];
    assign in_cy  = s_tdata[143:128];
    assign in_dc  = s_tdata[167:144];
    assign in_col = s_tdata[191:168];

    // Configuration registers
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COLOR_W-1:0] bg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            bg_reg     <= BG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_BG:     bg_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    state_t                    state_reg, state_next;
    logic [2:0]                step_reg, step_next;
    logic [PIX_AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [COLOR_W-1:0]        clr_col_reg, clr_col_next;

    logic signed [CRD_W-1:0]   xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg;
    logic signed [DEPTH_W-1:0] da_reg, db_reg, dc_reg;
    logic [COLOR_W-1:0]        col_reg;

    logic signed [BOX_W-1:0]   left_reg, left_next, right_reg, right_next;
    logic signed [BOX_W-1:0]   top_reg, top_next, bottom_reg, bottom_next;
    logic signed [BOX_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [DIFF_W-1:0]  dxba_reg, dxba_next, dyba_reg, dyba_next;
    logic signed [DIFF_W-1:0]  dxca_reg, dxca_next, dyca_reg, dyca_next;
    logic                      sgn_reg, sgn_next;
    logic [AREA_W-1:0]         area_reg, area_next;
    logic signed [STEP_W-1:0]  xs0_reg, xs0_next, xs1_reg, xs1_next;
    logic signed [STEP_W-1:0]  ys0_reg, ys0_next, ys1_reg, ys1_next;
    logic signed [EDGE_W-1:0]  e0_reg, e0_next, e1_reg, e1_next;
    logic signed [EDGE_W-1:0]  e0_row_reg, e0_row_next, e1_row_reg, e1_row_next;

    logic                      m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0]        m_color_reg, m_color_next;
    logic signed [DEPTH_W-1:0] m_depth_reg, m_depth_next;

    // Unit connections
    mac_op_t                   mac_op;
    logic signed [ACC_W-1:0]   acc;
    logic                      div_start;
    logic                      div_done;
    logic signed [Q_W-1:0]     div_quot;
    pix_req_t                  pix_req;
    logic [COLOR_W-1:0]        rd_color;
    logic signed [DEPTH_W-1:0] rd_depth;

    trd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .acc     (acc)
    );

    trd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc),
        .den     (area_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    trd_pixel_store u_store (
        .aclk     (aclk),
        .req      (pix_req),
        .rd_color (rd_color),
        .rd_depth (rd_depth)
    );

    // Bounding box, clipped to the active viewport
    logic signed [CRD_W-1:0]  mnx, mxx, mny, mxy;
    logic signed [CRD_W:0]    cx_up, cy_up;
    logic signed [BOX_W-1:0]  flx, fly, clx, cly, ewm1, ehm1;
    logic signed [BOX_W-1:0]  box_l, box_r, box_t, box_b;

    always_comb begin
        mnx   = min3(xa_reg, xb_reg, xc_reg);
        mxx   = max3(xa_reg, xb_reg, xc_reg);
        mny   = min3(ya_reg, yb_reg, yc_reg);
        mxy   = max3(ya_reg, yb_reg, yc_reg);
        cx_up = (CRD_W+1)'(mxx) + (CRD_W+1)'(15);
        cy_up = (CRD_W+1)'(mxy) + (CRD_W+1)'(15);
        flx   = BOX_W'(mnx >>> 4);
        fly   = BOX_W'(mny >>> 4);
        clx   = BOX_W'(cx_up >>> 4);
        cly   = BOX_W'(cy_up >>> 4);
        ewm1  = ((BOX_W'(width_reg) > BOX_W'(MAX_WIDTH)) ? BOX_W'(MAX_WIDTH)
                                                         : BOX_W'(width_reg)) - BOX_W'(1);
        ehm1  = ((BOX_W'(height_reg) > BOX_W'(MAX_HEIGHT)) ? BOX_W'(MAX_HEIGHT)
                                                           : BOX_W'(height_reg)) - BOX_W'(1);
        box_l = (flx < 0) ? '0 : flx;
        box_t = (fly < 0) ? '0 : fly;
        box_r = (clx > ewm1) ? ewm1 : clx;
        box_b = (cly > ehm1) ? ehm1 : cly;
    end

    // Offsets of the first pixel center from vertex A
    logic signed [MAC_B_W-1:0] py_off, px_off;

    assign py_off = (MAC_B_W'(top_reg) <<< 4) + MAC_B_W'(8) - MAC_B_W'(ya_reg);
    assign px_off = (MAC_B_W'(left_reg) <<< 4) + MAC_B_W'(8) - MAC_B_W'(xa_reg);

    // Edge e2 and coverage
    logic signed [EDGE_W-1:0] e2;
    logic                     covered;

    assign e2      = $signed(EDGE_W'(area_reg)) - e0_reg - e1_reg;
    assign covered = !e0_reg[EDGE_W-1] && !e1_reg[EDGE_W-1] && !e2[EDGE_W-1];

    // Shared unit operations for each sequencer step
    function automatic mac_op_t mk_op(
        input logic                       clr,
        input logic                       sub,
        input logic                       hi,
        input logic signed [MAC_A_W-1:0]  a,
        input logic signed [MAC_B_W-1:0]  b
    );
        mac_op_t o;
        o.valid = 1'b1;
        o.clear = clr;
        o.sub   = sub;
        o.hi    = hi;
        o.a     = a;
        o.b     = b;
        return o;
    endfunction

    function automatic logic signed [MAC_B_W-1:0] lo_part(input logic signed [EDGE_W-1:0] e);
        return $signed({1'b0, e[LO_W-1:0]});
    endfunction

    function automatic logic signed [MAC_B_W-1:0] hi_part(input logic signed [EDGE_W-1:0] e);
        return e[EDGE_W-1:LO_W];
    endfunction

    always_comb begin
        mac_op = '0;
        unique case (state_reg)
            S_AREA: begin
                if (step_reg == 3'd0) begin
                    mac_op = mk_op(1'b1, 1'b0, 1'b0, MAC_A_W'(dxba_reg), MAC_B_W'(dyca_reg));
                end else if (step_reg == 3'd1) begin
                    mac_op = mk_op(1'b0, 1'b1, 1'b0, MAC_A_W'(dxca_reg), MAC_B_W'(dyba_reg));
                end
            end
            S_EDGE0: begin
                if (step_reg == 3'd0) begin
                    mac_op = mk_op(1'b1, 1'b0, 1'b0, MAC_A_W'(dxba_reg), py_off);
                end else if (step_reg == 3'd1) begin
                    mac_op = mk_op(1'b0, 1'b1, 1'b0, MAC_A_W'(px_off), MAC_B_W'(dyba_reg));
                end
            end
            S_EDGE1: begin
                if (step_reg == 3'd0) begin
                    mac_op = mk_op(1'b1, 1'b0, 1'b0, MAC_A_W'(px_off), MAC_B_W'(dyca_reg));
                end else if (step_reg == 3'd1) begin
                    mac_op = mk_op(1'b0, 1'b1, 1'b0, MAC_A_W'(dxca_reg), py_off);
                end
            end
            S_DEPTH: begin
                unique case (step_reg)
                    3'd0: mac_op = mk_op(1'b1, 1'b0, 1'b0, MAC_A_W'(da_reg), lo_part(e2));
                    3'd1: mac_op = mk_op(1'b0, 1'b0, 1'b1, MAC_A_W'(da_reg), hi_part(e2));
                    3'd2: mac_op = mk_op(1'b0, 1'b0, 1'b0, MAC_A_W'(db_reg), lo_part(e1_reg));
                    3'd3: mac_op = mk_op(1'b0, 1'b0, 1'b1, MAC_A_W'(db_reg), hi_part(e1_reg));
                    3'd4: mac_op = mk_op(1'b0, 1'b0, 1'b0, MAC_A_W'(dc_reg), lo_part(e0_reg));
                    3'd5: mac_op = mk_op(1'b0, 1'b0, 1'b1, MAC_A_W'(dc_reg), hi_part(e0_reg));
                    default: mac_op = '0;
                endcase
            end
            default: mac_op = '0;
        endcase
    end

    // Accumulator with the orientation sign applied
    logic signed [EDGE_W-1:0]  acc_edge;
    logic signed [STEP_W-1:0]  dyba16, dyca16, dxba16, dxca16;

    assign acc_edge = sgn_reg ? -EDGE_W'(acc) : EDGE_W'(acc);
    assign dyba16   = STEP_W'(dyba_reg) <<< 4;
    assign dyca16   = STEP_W'(dyca_reg) <<< 4;
    assign dxba16   = STEP_W'(dxba_reg) <<< 4;
    assign dxca16   = STEP_W'(dxca_reg) <<< 4;

    // Store access
    always_comb begin
        pix_req.we    = 1'b0;
        pix_req.addr  = pix_index(x_reg, y_reg);
        pix_req.color = col_reg;
        pix_req.depth = div_quot;
        if (state_reg == S_CLEAR) begin
            pix_req.we    = 1'b1;
            pix_req.addr  = clr_cnt_reg;
            pix_req.color = clr_col_reg;
            pix_req.depth = DEPTH_MIN;
        end else if (state_reg == S_WRITE) begin
            pix_req.we    = (div_quot > rd_depth);
        end
    end

    assign div_start = (state_reg == S_DIV_GO);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            clr_cnt_reg <= '0;
            clr_col_reg <= BG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_col_reg <= clr_col_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            xa_reg  <= in_ax;
            ya_reg  <= in_ay;
            xb_reg  <= in_bx;
            yb_reg  <= in_by;
            xc_reg  <= in_cx;
            yc_reg  <= in_cy;
            da_reg  <= in_da;
            db_reg  <= in_db;
            dc_reg  <= in_dc;
            col_reg <= in_col;
        end
        left_reg    <= left_next;
        right_reg   <= right_next;
        top_reg     <= top_next;
        bottom_reg  <= bottom_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        dxba_reg    <= dxba_next;
        dyba_reg    <= dyba_next;
        dxca_reg    <= dxca_next;
        dyca_reg    <= dyca_next;
        sgn_reg     <= sgn_next;
        area_reg    <= area_next;
        xs0_reg     <= xs0_next;
        xs1_reg     <= xs1_next;
        ys0_reg     <= ys0_next;
        ys1_reg     <= ys1_next;
        e0_reg      <= e0_next;
        e1_reg      <= e1_next;
        e0_row_reg  <= e0_row_next;
        e1_row_reg  <= e1_row_next;
        m_color_reg <= m_color_next;
        m_depth_reg <= m_depth_next;
    end

    // Next state and datapath
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_col_next = clr_col_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        top_next     = top_reg;
        bottom_next  = bottom_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        dxba_next    = dxba_reg;
        dyba_next    = dyba_reg;
        dxca_next    = dxca_reg;
        dyca_next    = dyca_reg;
        sgn_next     = sgn_reg;
        area_next    = area_reg;
        xs0_next     = xs0_reg;
        xs1_next     = xs1_reg;
        ys0_next     = ys0_reg;
        ys1_next     = ys1_reg;
        e0_next      = e0_reg;
        e1_next      = e1_reg;
        e0_row_next  = e0_row_reg;
        e1_row_next  = e1_row_reg;
        m_color_next = m_color_reg;
        m_depth_next = m_depth_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;

        unique case (state_reg)
            // Sweep the store, one entry a cycle
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PIX_AW'(PIXELS - 1)) begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end

            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x_next = BOX_W'(in_ax >>> 4);
                    y_next = BOX_W'(in_ay >>> 4);
                    unique case (act_t'(s_tuser))
                        ACT_CLEAR: begin
                            clr_col_next = bg_reg;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        ACT_DRAW: state_next = S_BOX;
                        ACT_READ: state_next = S_RD_ADDR;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end

            // Wait for the registered read
            S_RD_ADDR: state_next = S_RD_OUT;

            // Hold until the output register is free
            S_RD_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (x_reg >= 0 && x_reg < BOX_W'(MAX_WIDTH) &&
                        y_reg >= 0 && y_reg < BOX_W'(MAX_HEIGHT)) begin
                        m_color_next = rd_color;
                        m_depth_next = rd_depth;
                    end else begin
                        m_color_next = bg_reg;
                        m_depth_next = DEPTH_MIN;
                    end
                    state_next = S_IDLE;
                end
            end

            // Clip the box, drop empty ones
            S_BOX: begin
                left_next   = box_l;
                right_next  = box_r;
                top_next    = box_t;
                bottom_next = box_b;
                dxba_next   = DIFF_W'(xb_reg) - DIFF_W'(xa_reg);
                dyba_next   = DIFF_W'(yb_reg) - DIFF_W'(ya_reg);
                dxca_next   = DIFF_W'(xc_reg) - DIFF_W'(xa_reg);
                dyca_next   = DIFF_W'(yc_reg) - DIFF_W'(ya_reg);
                step_next   = '0;
                if (box_l > box_r || box_t > box_b) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_AREA;
                end
            end

            S_AREA: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd2) begin
                    step_next  = '0;
                    state_next = S_AREA_CHK;
                end
            end

            // Drop zero-area triangles, set orientation and pixel steps
            S_AREA_CHK: begin
                sgn_next  = acc[ACC_W-1];
                area_next = acc[ACC_W-1] ? AREA_W'(-acc) : AREA_W'(acc);
                xs0_next  = acc[ACC_W-1] ? dyba16 : -dyba16;
                xs1_next  = acc[ACC_W-1] ? -dyca16 : dyca16;
                ys0_next  = acc[ACC_W-1] ? -dxba16 : dxba16;
                ys1_next  = acc[ACC_W-1] ? dxca16 : -dxca16;
                if (acc == '0) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_EDGE0;
                end
            end

            S_EDGE0: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd2) begin
                    step_next  = '0;
                    state_next = S_EDGE1;
                end
            end

            S_EDGE1: begin
                if (step_reg == 3'd0) begin
                    e0_next     = acc_edge;
                    e0_row_next = acc_edge;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd2) begin
                    step_next  = '0;
                    state_next = S_EDGE_END;
                end
            end

            S_EDGE_END: begin
                e1_next     = acc_edge;
                e1_row_next = acc_edge;
                x_next      = left_reg;
                y_next      = top_reg;
                state_next  = S_PIX;
            end

            S_DEPTH: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd6) begin
                    step_next  = '0;
                    state_next = S_DIV_GO;
                end
            end

            S_DIV_GO: state_next = S_DIV_WAIT;

            S_DIV_WAIT: begin
                if (div_done) begin
                    state_next = S_WRITE;
                end
            end

            default: ;
        endcase

        // Test a pixel; advance past an uncovered one or after a write
        if ((state_reg == S_PIX && covered)) begin
            step_next  = '0;
            state_next = S_DEPTH;
        end else if (state_reg == S_PIX || state_reg == S_WRITE) begin
            state_next = S_PIX;
            if (x_reg == right_reg) begin
                if (y_reg == bottom_reg) begin
                    state_next = S_IDLE;
                end else begin
                    y_next      = y_reg + 1'b1;
                    x_next      = left_reg;
                    e0_row_next = e0_row_reg + EDGE_W'(ys0_reg);
                    e1_row_next = e1_row_reg + EDGE_W'(ys1_reg);
                    e0_next     = e0_row_reg + EDGE_W'(ys0_reg);
                    e1_next     = e1_row_reg + EDGE_W'(ys1_reg);
                end
            end else begin
                x_next  = x_reg + 1'b1;
                e0_next = e0_reg + EDGE_W'(xs0_reg);
                e1_next = e1_reg + EDGE_W'(xs1_reg);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_depth_reg, m_color_reg};

endmodule

`default_nettype wire

// ===== test/tb_triangle_raster_depth_test.sv =====
// ----------------------------------------------------------------------------
// tb_triangle_raster_depth_test: self-checking bench of the triangle rasterizer
// Drives clears, draws, pixel reads and unused actions through the stream
// port with random gaps and back-pressure. It also sweeps the viewport and
// background registers through several settings, extremes included. A
// scoreboard keeps its own copy of the color and depth stores, predicts each
// pixel read and compares it with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_triangle_raster_depth_test;
    import trd_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int CLEAR_SETTLE = 70000;
    localparam int DRAW_SETTLE = 6000;

    typedef struct {
        logic [1:0]                 action;
        logic signed [CRD_W-1:0]    ax, ay, bx, by_c, cx, cy;
        logic signed [DEPTH_W-1:0]  ad, bd, cd;
        logic [COLOR_W-1:0]         fill;
    } tri_item_t;

    // Tracks the stores and the expected pixel reads
    class pixel_scoreboard;
        logic [COLOR_W-1:0]         color_mem [PIXELS];
        logic signed [DEPTH_W-1:0]  depth_mem [PIXELS];
        int                         width_reg;
        int                         height_reg;
        logic [COLOR_W-1:0]         bg_reg;
        logic [47:0]                pixel_q[$];
        int                         errors;

        function new();
            width_reg = 256;
            height_reg = 256;
            bg_reg = BG_RESET;
            errors = 0;
            fill_background();
        endfunction

        function void fill_background();
            for (int i = 0; i < PIXELS; i++) begin
                color_mem[i] = bg_reg;
                depth_mem[i] = DEPTH_MIN;
            end
        endfunction

        function void write_reg(cfg_t idx, logic [23:0] v);
            case (idx)
                CFG_WIDTH:  width_reg = v[DIM_W-1:0];
                CFG_HEIGHT: height_reg = v[DIM_W-1:0];
                CFG_BG:     bg_reg = v;
                default: ;
            endcase
        endfunction

        // Apply one accepted transaction to the stores
        function void note_item(tri_item_t it);
            longint xa, ya, da, xb, yb, db, xc, yc, dc;
            longint vw, vh, left, right, top, bottom, area, sgn;
            longint px, py, e0, e1, e2, d, rx, ry;
            int idx;
            if (it.action == ACT_CLEAR) begin
                fill_background();
            end else if (it.action == ACT_READ) begin
                rx = longint'(it.ax) >>> 4;
                ry = longint'(it.ay) >>> 4;
                if (rx < 0 || rx >= MAX_WIDTH || ry < 0 || ry >= MAX_HEIGHT) begin
                    pixel_q.push_back({DEPTH_MIN, bg_reg});
                end else begin
                    idx = int'(ry * MAX_WIDTH + rx);
                    pixel_q.push_back({depth_mem[idx], color_mem[idx]});
                end
            end else if (it.action == ACT_DRAW) begin
                xa = it.ax; ya = it.ay; da = it.ad;
                xb = it.bx; yb = it.by_c; db = it.bd;
                xc = it.cx; yc = it.cy; dc = it.cd;
                vw = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
                vh = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
                left = xa; if (xb < left) left = xb; if (xc < left) left = xc;
                right = xa; if (xb > right) right = xb; if (xc > right) right = xc;
                top = ya; if (yb < top) top = yb; if (yc < top) top = yc;
                bottom = ya; if (yb > bottom) bottom = yb; if (yc > bottom) bottom = yc;
                // floor of the minimum, ceil of the maximum, then clip
                left = left >>> 4;
                top = top >>> 4;
                right = -((-right) >>> 4);
                bottom = -((-bottom) >>> 4);
                if (left < 0) left = 0;
                if (top < 0) top = 0;
                if (right > vw - 1) right = vw - 1;
                if (bottom > vh - 1) bottom = vh - 1;
                area = (xb - xa) * (yc - ya) - (xc - xa) * (yb - ya);
                if (left > right || top > bottom || area == 0)
                    return;
                sgn = (area < 0) ? -1 : 1;
                area = area * sgn;
                for (longint y = top; y <= bottom; y++) begin
                    py = y * 16 + 8;
                    for (longint x = left; x <= right; x++) begin
                        px = x * 16 + 8;
                        e0 = sgn * ((xb - xa) * (py - ya) - (px - xa) * (yb - ya));
                        e1 = sgn * ((px - xa) * (yc - ya) - (xc - xa) * (py - ya));
                        e2 = area - e0 - e1;
                        if (e0 >= 0 && e1 >= 0 && e2 >= 0) begin
                            d = (da * e2 + db * e1 + dc * e0) / area;
                            idx = int'(y * MAX_WIDTH + x);
                            if (d > longint'(depth_mem[idx])) begin
                                depth_mem[idx] = d[DEPTH_W-1:0];
                                color_mem[idx] = it.fill;
                            end
                        end
                    end
                end
            end
        endfunction

        // Compare one returned pixel with the oldest prediction
        function void check_pixel(logic [47:0] got);
            logic [47:0] want;
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected pixel, actual %h", $time, got);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            if (got[23:0] !== want[23:0]) begin
                $display("%0t: pixel_color mismatch, expected %h actual %h",
                         $time, want[23:0], got[23:0]);
                errors++;
            end
            if (got[47:24] !== want[47:24]) begin
                $display("%0t: pixel_depth mismatch, expected %0d actual %0d",
                         $time, $signed(want[47:24]), $signed(got[47:24]));
                errors++;
            end
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [191:0]   s_tdata;
    logic [1:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [47:0]    m_tdata;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [23:0]    cfg_data;

    pixel_scoreboard pixels;
    bit              no_idle;
    bit              last_was_clear;
    int              cycles;

    triangle_raster_depth_test DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check every pixel transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            pixels.check_pixel(m_tdata);
    end

    // Stall the result side at random
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready = 1'b0;
            repeat (no_idle ? 0 : $urandom_range(0, 16)) @(negedge aclk);
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic tri_item_t make_tri(logic [1:0] act, int ax, int ay, int ad,
                                           int bx, int by_c, int bd, int cx, int cy,
                                           int cd, logic [23:0] fill);
        tri_item_t t;
        t.action = act;
        t.ax = CRD_W'(ax); t.ay = CRD_W'(ay); t.ad = DEPTH_W'(ad);
        t.bx = CRD_W'(bx); t.by_c = CRD_W'(by_c); t.bd = DEPTH_W'(bd);
        t.cx = CRD_W'(cx); t.cy = CRD_W'(cy); t.cd = DEPTH_W'(cd);
        t.fill = fill;
        return t;
    endfunction

    // Random transaction: small triangles unless wide; reads mostly near origin
    function automatic tri_item_t make_random(bit wide);
        tri_item_t t;
        int pick, bx0, by0, span;
        pick = $urandom_range(0, 99);
        t = make_tri(ACT_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, COLOR_W'($urandom));
        if (pick < 3) begin
            t.action = ACT_UNUSED;
        end else if (pick < 40) begin
            t.action = ACT_READ;
            if ($urandom_range(0, 9) != 0) begin
                t.ax = CRD_W'($urandom_range(0, 40 * 16 - 1));
                t.ay = CRD_W'($urandom_range(0, 40 * 16 - 1));
            end
        end else if (!wide || $urandom_range(0, 3) == 0) begin
            // small triangle, occasionally poking past the left / top border
            bx0 = $urandom_range(0, 32 * 16) - 64;
            by0 = $urandom_range(0, 32 * 16) - 64;
            span = ($urandom_range(0, 3) == 0) ? 24 : 80;
            t.ax = CRD_W'(bx0 + int'($urandom_range(0, 2 * span)) - span);
            t.ay = CRD_W'(by0 + int'($urandom_range(0, 2 * span)) - span);
            t.bx = CRD_W'(bx0 + int'($urandom_range(0, 2 * span)) - span);
            t.by_c = CRD_W'(by0 + int'($urandom_range(0, 2 * span)) - span);
            t.cx = CRD_W'(bx0 + int'($urandom_range(0, 2 * span)) - span);
            t.cy = CRD_W'(by0 + int'($urandom_range(0, 2 * span)) - span);
            if ($urandom_range(0, 2) == 0) begin
                // narrow depth range so that ties happen
                t.ad = DEPTH_W'(int'($urandom_range(0, 8)) - 4);
                t.bd = DEPTH_W'(int'($urandom_range(0, 8)) - 4);
                t.cd = DEPTH_W'(int'($urandom_range(0, 8)) - 4);
            end
        end
        return t;
    endfunction

    task automatic send_item(tri_item_t it);
        repeat (no_idle ? 0 : $urandom_range(0, 16)) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser = it.action;
        s_tdata = {it.fill, it.cd, it.cy, it.cx, it.bd, it.by_c, it.bx, it.ad, it.ay, it.ax};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pixels.note_item(it);
        last_was_clear = (it.action == ACT_CLEAR);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pixels.pixel_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Settle the block, then write the three registers
    task automatic configure(logic [8:0] w, logic [8:0] h, logic [23:0] bg);
        logic [23:0] vals [3];
        drain();
        repeat (last_was_clear ? CLEAR_SETTLE : DRAW_SETTLE) @(posedge aclk);
        @(negedge aclk);
        vals[0] = 24'(w); vals[1] = 24'(h); vals[2] = bg;
        for (int i = 0; i < 3; i++) begin
            cfg_index = cfg_t'(i);
            cfg_data = vals[i];
            cfg_valid = 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            pixels.write_reg(cfg_t'(i), vals[i]);
            @(negedge aclk);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic run_random(int count, bit wide);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 39) == 0)
                no_idle = ~no_idle;
            send_item(make_random(wide));
        end
    endtask

    initial begin
        pixels = new();
        cycles = 0;
        no_idle = 1'b0;
        last_was_clear = 1'b1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_CLEAR;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reads at the store borders and outside it
        send_item(make_tri(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, 255 * 16 + 15, 255 * 16 + 15, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, 256 * 16, 3 * 16, 0, 0, 0, 0, 0, 0, 0, 0));
        // Both windings, depth extremes, a losing and a winning overdraw
        send_item(make_tri(ACT_DRAW, 0, 0, 1000, 160, 0, 1000, 0, 160, 1000, 24'h123456));
        send_item(make_tri(ACT_DRAW, 0, 0, 2000, 0, 160, 2000, 160, 0, 2000, 24'hFFFFFF));
        send_item(make_tri(ACT_DRAW, 0, 0, 1500, 160, 0, 1500, 0, 160, 1500, 24'h000001));
        send_item(make_tri(ACT_DRAW, 32, 32, -8388608, 200, 40, -8388608, 40, 200,
                           -8388608, 24'h00FF00));
        send_item(make_tri(ACT_DRAW, 200, 200, 8388607, 300, 200, -8388608, 200, 300,
                           8388607, 24'h000000));
        // Zero area: collinear and a single point
        send_item(make_tri(ACT_DRAW, 0, 0, 5000, 80, 80, 5000, 160, 160, 5000, 24'hABCDEF));
        send_item(make_tri(ACT_DRAW, 48, 48, 5000, 48, 48, 5000, 48, 48, 5000, 24'hABCDEF));
        send_item(make_tri(ACT_UNUSED, 0, 0, 9000, 160, 0, 9000, 0, 160, 9000, 24'h777777));
        send_item(make_tri(ACT_READ, 1 * 16, 1 * 16, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, 9 * 16, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, 3 * 16, 3 * 16, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, 13 * 16, 13 * 16, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_READ, 1 * 16, 1 * 16, 0, 0, 0, 0, 0, 0, 0, 0));
        run_random(140, 1'b0);

        // Tiny viewport: full-range vertices, huge triangles get clipped
        configure(9'd5, 9'd3, 24'hFFFFFF);
        send_item(make_tri(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(ACT_DRAW, -32768, -32768, 100, 32767, -32768, 200, -32768, 32767,
                           300, 24'hFFFFFF));
        run_random(80, 1'b1);

        // Oversized viewport saturates to the store size
        configure(9'd511, 9'd511, 24'h000000);
        send_item(make_tri(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        run_random(60, 1'b0);
        drain();
        run_random(60, 1'b0);

        // Empty viewports, where nothing may be drawn, then a single-pixel one
        configure(9'd1, 9'd0, COLOR_W'($urandom));
        run_random(25, 1'b1);
        configure(9'd0, 9'd1, COLOR_W'($urandom));
        run_random(25, 1'b1);
        configure(9'd1, 9'd1, COLOR_W'($urandom));
        run_random(30, 1'b1);

        configure(9'd300, 9'd40, COLOR_W'($urandom));
        send_item(make_tri(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        run_random(60, 1'b0);

        drain();
        repeat (200) @(posedge aclk);
        if (pixels.errors == 0 && pixels.pixel_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/trd_pkg.sv
design/trd_mac.sv
design/trd_divider.sv
design/trd_pixel_store.sv
design/triangle_raster_depth_test.sv
test/tb_triangle_raster_depth_test.sv
